[design/ktsc_pkg.sv]
// Shared types and constants of the keyed top-k score table.
package ktsc_pkg;

	localparam int KEY_IN_W = 16;
	localparam int SCORE_W  = 32;
	localparam int POS_W    = 5;
	localparam int CFG_W    = 5;

	localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 5'd10;

	typedef struct packed {
		logic [KEY_IN_W-1:0]       player_key;
		logic signed [SCORE_W-1:0] new_score;
	} item_in_t;

	typedef struct packed {
		logic [POS_W-1:0] old_position;
		logic [POS_W-1:0] new_position;
		logic             in_table;
		logic [POS_W-1:0] entry_total;
	} item_out_t;

endpackage

[design/keyed_top_k_score_table.sv]
// Top level of the keyed top-k score table: sequencer, shared compare unit and table RAM.
//
// The block keeps up to min(max_entries, DEPTH) (key, score) entries sorted by score from
// highest to lowest. An item is taken when start is high and busy is low; it sets the score
// of one key. Any entry holding that key is removed, and the new entry is placed in front of
// the first entry with a strictly lower score (so it lands behind entries of equal score),
// or at the end when there is still room, otherwise the key drops out. The table sits in one
// RAM with a single registered read port, and every entry that is looked at or moved goes
// through it one at a time: the search pass reads and then compares each held entry, and
// the move pass reads and then writes each shifted entry. The result appears on rsp with
// done high for exactly one cycle; the receiver cannot stall it, and busy drops in that
// same cycle so the next item may start at once. max_entries is written through the cfg
// channel, which is ready only while the block is idle; lowering the limit cuts entries from
// the tail immediately. The RAM needs no clearing after reset because only entries below the
// fill count are ever read.
module keyed_top_k_score_table #(
	parameter int DEPTH    = 16,
	parameter int KEY_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  ktsc_pkg::item_in_t                req,
	output logic                              done,
	output ktsc_pkg::item_out_t               rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ktsc_pkg::CFG_W-1:0]        cfg_data
);

	import ktsc_pkg::*;

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int LW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int MEM_W = KEY_BITS + SCORE_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_PLAN,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_PUT,
		ST_FIN
	} state_t;

	state_t                    state_q;
	logic [CFG_W-1:0]          max_entries_q;
	logic [CNT_W-1:0]          filled_q;
	logic [KEY_BITS-1:0]       key_q;
	logic signed [SCORE_W-1:0] score_q;
	logic [CNT_W-1:0]          i_q;
	logic                      found_q;
	logic [CNT_W-1:0]          o_q;
	logic                      pfound_q;
	logic [CNT_W-1:0]          p_q;
	logic                      added_q;
	logic [CNT_W-1:0]          fin_q;
	logic                      move_q;
	logic                      left_q;
	logic [CNT_W-1:0]          j_q;
	logic [CNT_W-1:0]          bound_q;
	logic                      done_q;
	item_out_t                 rsp_q;

	// RAM ports.
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [MEM_W-1:0]          ram_wdata;
	logic [AW-1:0]             ram_raddr;
	logic [MEM_W-1:0]          ram_rdata;

	logic [KEY_BITS-1:0]       rd_key;
	logic signed [SCORE_W-1:0] rd_score;
	logic [KEY_IN_W+KEY_BITS-1:0] key_wide;
	logic [KEY_BITS-1:0]       key_in;

	// The current limit and the limit that a configuration write would set.
	logic [LW-1:0]             me_w;
	logic [LW-1:0]             lim_w;
	logic [CNT_W-1:0]          lim_c;
	logic [LW-1:0]             cfg_me_w;
	logic [LW-1:0]             cfg_lim_w;
	logic [CNT_W-1:0]          cfg_lim_c;

	// Plan of the rewrite, worked out once the search pass has finished.
	logic [CNT_W-1:0]          f1_c;
	logic                      room_c;
	logic                      add_c;
	logic [CNT_W-1:0]          pp_c;
	logic [CNT_W-1:0]          fin_c;
	logic                      left_c;
	logic                      right_c;
	logic [CNT_W-1:0]          last_c;
	logic [CNT_W-1:0]          jstart_c;
	logic [CNT_W-1:0]          bound_c;

	logic                      key_hit;
	logic                      score_gt;
	logic                      move_go;
	logic [CNT_W-1:0]          src_c;
	logic [CNT_W:0]            o_inc;
	logic [CNT_W:0]            p_inc;

	assign key_wide = {{KEY_BITS{1'b0}}, req.player_key};
	assign key_in   = key_wide[KEY_BITS-1:0];

	assign rd_key   = ram_rdata[MEM_W-1:SCORE_W];
	assign rd_score = $signed(ram_rdata[SCORE_W-1:0]);

	// The shared compare unit: one key match and one signed score compare per visited entry.
	assign key_hit  = (rd_key == key_q);
	assign score_gt = (score_q > rd_score);

	assign me_w      = LW'(max_entries_q);
	assign lim_w     = (me_w > LW'(DEPTH)) ? LW'(DEPTH) : me_w;
	assign lim_c     = lim_w[CNT_W-1:0];
	assign cfg_me_w  = LW'(cfg_data);
	assign cfg_lim_w = (cfg_me_w > LW'(DEPTH)) ? LW'(DEPTH) : cfg_me_w;
	assign cfg_lim_c = cfg_lim_w[CNT_W-1:0];

	// Removing the old entry shifts a run of entries left, inserting shifts a run right.
	// Entries outside the run between the two positions keep their slots.
	always_comb begin
		f1_c     = filled_q - CNT_W'(found_q);
		room_c   = (f1_c < lim_c);
		add_c    = pfound_q | room_c;
		pp_c     = pfound_q ? p_q : f1_c;
		fin_c    = add_c ? (room_c ? f1_c + CNT_W'(1) : lim_c) : f1_c;
		left_c   = found_q && (!add_c || (o_q < pp_c));
		right_c  = add_c && (!found_q || (pp_c <= o_q));
		last_c   = fin_c - CNT_W'(1);
		jstart_c = left_c ? o_q : ((found_q && (o_q < last_c)) ? o_q : last_c);
		bound_c  = left_c ? (add_c ? pp_c : f1_c) : pp_c;
	end

	assign move_go = move_q && (left_q ? (j_q < bound_q) : (j_q > bound_q));
	assign src_c   = left_q ? (j_q + CNT_W'(1)) : (j_q - CNT_W'(1));
	assign o_inc   = {1'b0, o_q} + (CNT_W+1)'(1);
	assign p_inc   = {1'b0, p_q} + (CNT_W+1)'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = ram_rdata;
		ram_raddr = '0;
		unique case (state_q)
			ST_SCAN_RD: begin
				ram_raddr = i_q[AW-1:0];
			end
			ST_MOVE_RD: begin
				ram_raddr = src_c[AW-1:0];
			end
			ST_MOVE_WR: begin
				ram_we    = 1'b1;
				ram_waddr = j_q[AW-1:0];
				ram_wdata = ram_rdata;
			end
			ST_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = p_q[AW-1:0];
				ram_wdata = {key_q, score_q};
			end
			ST_IDLE, ST_SCAN_CMP, ST_PLAN, ST_FIN: begin
				ram_we = 1'b0;
			end
		endcase
	end

	ktsc_ram #(
		.WIDTH (MEM_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			max_entries_q <= MAX_ENTRIES_RESET;
			filled_q      <= '0;
			key_q         <= '0;
			score_q       <= '0;
			i_q           <= '0;
			found_q       <= 1'b0;
			o_q           <= '0;
			pfound_q      <= 1'b0;
			p_q           <= '0;
			added_q       <= 1'b0;
			fin_q         <= '0;
			move_q        <= 1'b0;
			left_q        <= 1'b0;
			j_q           <= '0;
			bound_q       <= '0;
			done_q        <= 1'b0;
			rsp_q         <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						max_entries_q <= cfg_data;
						if (filled_q > cfg_lim_c) begin
							filled_q <= cfg_lim_c;
						end
					end
					if (start) begin
						key_q    <= key_in;
						score_q  <= req.new_score;
						i_q      <= '0;
						found_q  <= 1'b0;
						pfound_q <= 1'b0;
						o_q      <= '0;
						p_q      <= '0;
						// A limit of zero written in the same cycle empties the table
						// before the search, so there is nothing to scan.
						state_q  <= ((filled_q == '0) || (cfg_valid && (cfg_lim_c == '0))) ?
							ST_PLAN : ST_SCAN_RD;
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CMP;
				end
				ST_SCAN_CMP: begin
					// An entry with the key is dropped, so it does not count as a place
					// for the new entry; later places shift down by one.
					if (!found_q && key_hit) begin
						found_q <= 1'b1;
						o_q     <= i_q;
					end else if (!pfound_q && score_gt) begin
						pfound_q <= 1'b1;
						p_q      <= i_q - CNT_W'(found_q);
					end
					i_q     <= i_q + CNT_W'(1);
					state_q <= ((i_q + CNT_W'(1)) < filled_q) ? ST_SCAN_RD : ST_PLAN;
				end
				ST_PLAN: begin
					added_q <= add_c;
					p_q     <= pp_c;
					fin_q   <= fin_c;
					move_q  <= left_c | right_c;
					left_q  <= left_c;
					j_q     <= jstart_c;
					bound_q <= bound_c;
					state_q <= ST_MOVE_RD;
				end
				ST_MOVE_RD: begin
					if (move_go) begin
						state_q <= ST_MOVE_WR;
					end else begin
						state_q <= added_q ? ST_PUT : ST_FIN;
					end
				end
				ST_MOVE_WR: begin
					j_q     <= src_c;
					state_q <= ST_MOVE_RD;
				end
				ST_PUT: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					filled_q            <= fin_q;
					rsp_q.old_position  <= found_q ? POS_W'(o_inc) : '0;
					rsp_q.new_position  <= added_q ? POS_W'(p_inc) : '0;
					rsp_q.in_table      <= added_q;
					rsp_q.entry_total   <= POS_W'(fin_q);
					done_q              <= 1'b1;
					state_q             <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign done      = done_q;
	assign rsp       = rsp_q;

endmodule

[design/ktsc_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module ktsc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[tb/keyed_top_k_score_table_tb.sv]
// Testbench for the keyed top-k score table: directed script, random phases, self-checking.
module keyed_top_k_score_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ktsc_pkg::*;

	// The table is built with its default size, so the predictor mirrors it.
	localparam int TABLE_DEPTH = 16;
	// The watchdog allows many times the longest item plus the longest sender gap.
	// The tail wait covers one slow item.
	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned TAIL_CYCLES = 80;
	localparam int unsigned PHASES      = 9;

	typedef enum bit {ROW_ITEM, ROW_LIMIT} row_kind_t;

	// One row of the directed script. A row is either a score item or a write of the limit.
	// Where typed is set, the expected result is written out in the row itself.
	typedef struct {
		row_kind_t           kind;
		logic [CFG_W-1:0]    limit;
		logic [KEY_IN_W-1:0] key;
		logic [SCORE_W-1:0]  score;
		bit                  typed;
		item_out_t           want;
	} script_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	item_in_t         req;
	logic             done;
	item_out_t        rsp;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	// Private copy of the table, its fill count and the limit register.
	logic [KEY_IN_W-1:0]       rank_key   [TABLE_DEPTH];
	logic signed [SCORE_W-1:0] rank_score [TABLE_DEPTH];
	int unsigned               rank_held;
	logic [CFG_W-1:0]          limit_reg;

	// Results still owed by the block, oldest first.
	item_out_t   expected_ranks [$];
	int unsigned mismatches;

	script_row_t directed [25];

	// Each random phase runs under its own limit and sender idling. The limits walk the
	// full range, including zero, the depth itself and a value above the depth, and several
	// steps lower the limit while the table is full.
	int unsigned phase_limit [PHASES] = '{16, 31, 1, 10, 0, 2, 16, 5, 3};
	int unsigned phase_items [PHASES] = '{110, 110, 90, 100, 20, 90, 110, 90, 80};
	int unsigned phase_idle  [PHASES] = '{0, 49, 36, 0, 49, 36, 0, 49, 36};

	keyed_top_k_score_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The usable limit never exceeds the depth of the table.
	function automatic int unsigned usable_limit();
		return (limit_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(limit_reg);
	endfunction

	// Entries past the limit fall off the tail.
	function automatic void cut_tail();
		if (rank_held > usable_limit())
			rank_held = usable_limit();
	endfunction

	function automatic void set_limit(input logic [CFG_W-1:0] value);
		limit_reg = value;
		cut_tail();
	endfunction

	// Applies one score update to the private table and returns the ranks it produces.
	function automatic item_out_t rank_update(input item_in_t it);
		item_out_t   res;
		int unsigned lim;
		int unsigned i;
		int unsigned j;
		lim = usable_limit();
		res = '0;
		cut_tail();
		// Drop any entry that already holds this key and close the gap.
		for (i = 0; i < rank_held; i++) begin
			if (rank_key[i] == it.player_key) begin
				res.old_position = POS_W'(i + 1);
				for (j = i; j + 1 < rank_held; j++) begin
					rank_key[j]   = rank_key[j + 1];
					rank_score[j] = rank_score[j + 1];
				end
				rank_held--;
				break;
			end
		end
		// Insert in front of the first strictly lower score, or at the end when there is room.
		for (i = 0; i < lim; i++) begin
			if (i >= rank_held || it.new_score > rank_score[i]) begin
				for (j = (rank_held < TABLE_DEPTH) ? rank_held : TABLE_DEPTH - 1; j > i; j--)
				begin
					rank_key[j]   = rank_key[j - 1];
					rank_score[j] = rank_score[j - 1];
				end
				rank_key[i]   = it.player_key;
				rank_score[i] = it.new_score;
				if (rank_held < TABLE_DEPTH)
					rank_held++;
				res.new_position = POS_W'(i + 1);
				res.in_table     = 1'b1;
				break;
			end
		end
		cut_tail();
		res.entry_total = POS_W'(rank_held);
		return res;
	endfunction

	// Random items mostly reuse a small pool of keys so that updates hit held entries, and
	// often use scores from a narrow band so that ties are common. The rest are fully random
	// or at the signed extremes.
	function automatic item_in_t pick_item();
		item_in_t    it;
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 80)
			it.player_key = KEY_IN_W'($urandom_range(23));
		else
			it.player_key = KEY_IN_W'($urandom);
		roll = $urandom_range(99);
		if (roll < 45) begin
			it.new_score = SCORE_W'($urandom_range(8) - 4);
		end else if (roll < 55) begin
			case ($urandom_range(3))
				0:       it.new_score = 32'h8000_0000;
				1:       it.new_score = 32'h8000_0001;
				2:       it.new_score = 32'h7FFF_FFFE;
				default: it.new_score = 32'h7FFF_FFFF;
			endcase
		end else begin
			it.new_score = SCORE_W'($urandom);
		end
		return it;
	endfunction

	// Lowers start and waits until every owed result has come back.
	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (expected_ranks.size() != 0)
			@(posedge clk);
	endtask

	// Offers one item, holding it until the block takes it. Before the item the sender may
	// idle: mostly short gaps, now and then one long enough to span a whole update. While
	// start is low the request bus carries noise that the block must ignore.
	task automatic send_score(input item_in_t it, input int unsigned idle_pct,
			input bit typed, input item_out_t typed_want);
		int unsigned gap;
		item_out_t   predicted;
		gap = 0;
		if ($urandom_range(99) < idle_pct)
			gap = ($urandom_range(9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 4);
		repeat (gap) begin
			@(negedge clk);
			start          = 1'b0;
			req.player_key = KEY_IN_W'($urandom);
			req.new_score  = SCORE_W'($urandom);
		end
		@(negedge clk);
		start = 1'b1;
		req   = it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// The item was taken at this edge. The predictor always runs so that its table
		// follows the block even where the row supplies the expected result.
		predicted = rank_update(it);
		expected_ranks.push_back(typed ? typed_want : predicted);
	endtask

	// The limit is written only once the block has returned every result and sits idle.
	task automatic write_limit(input logic [CFG_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		set_limit(value);
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data  = CFG_W'($urandom);
	endtask

	// Every result must match the oldest owed one, field by field.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_ranks.size() == 0) begin
				$display("%0t: result with nothing owed: old %0d new %0d in %0b total %0d",
					$time, rsp.old_position, rsp.new_position, rsp.in_table,
					rsp.entry_total);
				mismatches++;
			end else begin
				if (rsp.old_position !== expected_ranks[0].old_position) begin
					$display("%0t: old_position expected %0d actual %0d", $time,
						expected_ranks[0].old_position, rsp.old_position);
					mismatches++;
				end
				if (rsp.new_position !== expected_ranks[0].new_position) begin
					$display("%0t: new_position expected %0d actual %0d", $time,
						expected_ranks[0].new_position, rsp.new_position);
					mismatches++;
				end
				if (rsp.in_table !== expected_ranks[0].in_table) begin
					$display("%0t: in_table expected %0b actual %0b", $time,
						expected_ranks[0].in_table, rsp.in_table);
					mismatches++;
				end
				if (rsp.entry_total !== expected_ranks[0].entry_total) begin
					$display("%0t: entry_total expected %0d actual %0d", $time,
						expected_ranks[0].entry_total, rsp.entry_total);
					mismatches++;
				end
				void'(expected_ranks.pop_front());
			end
		end
	end

	// Ends the run when nothing has moved for too long: no item taken, no result, no write.
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL keyed_top_k_score_table");
		$finish;
	end

	initial begin
		int unsigned p;
		int unsigned n;
		item_in_t    it;
		// The script starts from the reset limit of ten. It fills an empty table with the key
		// and score extremes, moves held keys up and down, puts equal scores behind each
		// other, fills the table and offers a score too low to get in, then lowers the limit
		// with the table full, sets it to zero, where no key is ever added, then sets it
		// above the depth, where it acts as the depth, and at last to the depth itself.
		directed = '{
			'{ROW_ITEM,  5'd0,  16'h0000, 32'h0000_0000, 1'b1, '{5'd0, 5'd1, 1'b1, 5'd1}},
			'{ROW_ITEM,  5'd0,  16'hFFFF, 32'h7FFF_FFFF, 1'b1, '{5'd0, 5'd1, 1'b1, 5'd2}},
			'{ROW_ITEM,  5'd0,  16'h8000, 32'h8000_0000, 1'b1, '{5'd0, 5'd3, 1'b1, 5'd3}},
			'{ROW_ITEM,  5'd0,  16'h0000, 32'h0000_0000, 1'b0, '0},
			'{ROW_ITEM,  5'd0,  16'h1234, 32'h0000_0000, 1'b0, '0},
			'{ROW_ITEM,  5'd0,  16'hFFFF, 32'h8000_0000, 1'b0, '0},
			'{ROW_ITEM,  5'd0,  16'h0001, 32'h0000_0064, 1'b0, '0},
			'{ROW_ITEM,  5'd0,  16'h0002, 32'hFFFF_FF9C, 1'b0, '0},
			'{ROW_ITEM,  5'd0,  16'h0003, 32'h7FFF_FFFF, 1'b0, '0},
			'{ROW_ITEM,  5'd0,  16'h0004, 32'h0000_0005, 1'b0, '0},
			'{ROW_ITEM,  5'd0,  16'h0005, 32'h8000_0001, 1'b0, '0},
			'{ROW_ITEM,  5'd0,  16'h0006, 32'h0000_0032, 1'b0, '0},
			'{ROW_ITEM,  5'd0,  16'h00AA, 32'h8000_0000, 1'b1, '{5'd0, 5'd0, 1'b0, 5'd10}},
			'{ROW_ITEM,  5'd0,  16'hFFFF, 32'h7FFF_FFFF, 1'b0, '0},
			'{ROW_ITEM,  5'd0,  16'h5555, 32'h5555_5555, 1'b0, '0},
			'{ROW_ITEM,  5'd0,  16'hAAAA, 32'hAAAA_AAAA, 1'b0, '0},
			'{ROW_LIMIT, 5'd3,  16'h0000, 32'h0000_0000, 1'b0, '0},
			'{ROW_ITEM,  5'd0,  16'h0BAD, 32'h0000_0000, 1'b0, '0},
			'{ROW_LIMIT, 5'd0,  16'h0000, 32'h0000_0000, 1'b0, '0},
			'{ROW_ITEM,  5'd0,  16'hFFFF, 32'h7FFF_FFFF, 1'b1, '{5'd0, 5'd0, 1'b0, 5'd0}},
			'{ROW_LIMIT, 5'd31, 16'h0000, 32'h0000_0000, 1'b0, '0},
			'{ROW_ITEM,  5'd0,  16'h0001, 32'h0000_0001, 1'b0, '0},
			'{ROW_ITEM,  5'd0,  16'h0002, 32'h0000_0002, 1'b0, '0},
			'{ROW_LIMIT, 5'd16, 16'h0000, 32'h0000_0000, 1'b0, '0},
			'{ROW_ITEM,  5'd0,  16'h0003, 32'h0000_0003, 1'b0, '0}
		};

		// Every input is known from time zero, before reset is released.
		arst_n     = 1'b0;
		start      = 1'b0;
		req        = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		mismatches = 0;
		rank_held  = 0;
		limit_reg  = MAX_ENTRIES_RESET;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, back to back with no idling.
		foreach (directed[r]) begin
			if (directed[r].kind == ROW_LIMIT) begin
				write_limit(directed[r].limit);
			end else begin
				it.player_key = directed[r].key;
				it.new_score  = directed[r].score;
				send_score(it, 0, directed[r].typed, directed[r].want);
			end
		end

		// Random phases. Now and then the sender also waits for the block to drain fully
		// in the middle of a phase.
		for (p = 0; p < PHASES; p++) begin
			write_limit(CFG_W'(phase_limit[p]));
			for (n = 0; n < phase_items[p]; n++) begin
				if ($urandom_range(99) == 0)
					wait_drained();
				send_score(pick_item(), phase_idle[p], 1'b0, '0);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_ranks.size() == 0)
			$display("PASS keyed_top_k_score_table");
		else
			$display("FAIL keyed_top_k_score_table");
		$finish;
	end

endmodule
